// File: rtl/core/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, operation and status codes, and controller/datapath
// interface types for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int OUT_W    = ((DATA_W + STATUS_W + 7) / 8) * 8;
  localparam int PAD_W    = OUT_W - DATA_W - STATUS_W;

  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_ALL   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic exec;     // input word accepted, apply its operation
    logic rd_clr;   // start of read out, rewind the read index
    logic rd_req;   // issue a store read at front + index
    logic rd_load;  // move store read data into the output register
  } deq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             empty;
    logic             full;
    logic             out_free;
    logic             rd_last;
    logic [CNT_W-1:0] count;
  } deq_sts_t;

endpackage

// File: rtl/core/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: accepts input words and sequences the read out of all entries.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [deq_pkg::MODE_W-1:0]    in_mode_i,
  output logic                          in_ready_o,
  input  deq_pkg::deq_sts_t             sts_i,
  output deq_pkg::deq_cmd_t             cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.exec = in_valid_i && sts_i.out_free;
        if (cmd_o.exec && (in_mode_i == deq_pkg::MODE_READ_ALL) && !sts_i.empty) begin
          cmd_o.rd_clr = 1'b1;
          state_d      = ST_RD_REQ;
        end
      end
      ST_RD_REQ: begin
        cmd_o.rd_req = 1'b1;
        state_d      = ST_RD_LOAD;
      end
      ST_RD_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.rd_load = 1'b1;
          state_d       = sts_i.rd_last ? ST_IDLE : ST_RD_REQ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/deq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring store, front pointer, entry count, read index and the
// output register.
// ----------------------------------------------------------------------------
module deq_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [deq_pkg::MODE_W-1:0]      in_mode_i,
  input  logic [deq_pkg::DATA_W-1:0]      in_value_i,
  input  deq_pkg::deq_cmd_t               cmd_i,
  output deq_pkg::deq_sts_t               sts_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [deq_pkg::DATA_W-1:0]      out_value_o,
  output logic [deq_pkg::STATUS_W-1:0]    out_status_o,
  output logic                            out_last_o
);

  // ring index of a sum that stays below twice the depth
  function automatic logic [deq_pkg::IDX_W-1:0] wrap_idx(input logic [deq_pkg::IDX_W:0] s);
    logic [deq_pkg::IDX_W:0] r;
    r = s;
    if (s >= (deq_pkg::IDX_W + 1)'(deq_pkg::DEPTH)) begin
      r = s - (deq_pkg::IDX_W + 1)'(deq_pkg::DEPTH);
    end
    return r[deq_pkg::IDX_W-1:0];
  endfunction

  logic [deq_pkg::IDX_W-1:0]    front_q, front_d;
  logic [deq_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [deq_pkg::IDX_W-1:0]    rd_idx_q, rd_idx_d;
  logic                         out_valid_q, out_valid_d;
  logic [deq_pkg::DATA_W-1:0]   out_value_q, out_value_d;
  logic [deq_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic                         out_last_q, out_last_d;

  logic                         is_push, is_pop, is_read;
  logic                         empty, full, rd_last, out_free, ack_load;
  logic [deq_pkg::IDX_W-1:0]    front_dec, front_inc, back_idx, rd_addr;
  logic [deq_pkg::IDX_W-1:0]    waddr;
  logic                         we;
  logic [deq_pkg::DATA_W-1:0]   rdata;

  assign is_push = (in_mode_i == deq_pkg::MODE_PUSH_FRONT) ||
                   (in_mode_i == deq_pkg::MODE_PUSH_BACK);
  assign is_pop  = (in_mode_i == deq_pkg::MODE_POP_FRONT) ||
                   (in_mode_i == deq_pkg::MODE_POP_BACK);
  assign is_read = (in_mode_i == deq_pkg::MODE_READ_ALL);

  assign empty    = (cnt_q == '0);
  assign full     = (cnt_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign rd_last  = ((deq_pkg::CNT_W'(rd_idx_q) + deq_pkg::CNT_W'(1)) == cnt_q);
  assign out_free = !out_valid_q || out_ready_i;

  assign front_dec = (front_q == '0) ? deq_pkg::IDX_W'(deq_pkg::DEPTH - 1)
                                     : front_q - deq_pkg::IDX_W'(1);
  assign front_inc = wrap_idx({1'b0, front_q} + (deq_pkg::IDX_W + 1)'(1));
  // count is below depth whenever the back slot is written
  assign back_idx  = wrap_idx({1'b0, front_q} + (deq_pkg::IDX_W + 1)'(cnt_q));
  assign rd_addr   = wrap_idx({1'b0, front_q} + {1'b0, rd_idx_q});

  assign we    = cmd_i.exec && is_push && !full;
  assign waddr = (in_mode_i == deq_pkg::MODE_PUSH_FRONT) ? front_dec : back_idx;

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (deq_pkg::DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_value_i),
    .re_i    (cmd_i.rd_req),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign ack_load = cmd_i.exec && (is_push || is_pop || (is_read && empty));

  always_comb begin
    front_d      = front_q;
    cnt_d        = cnt_q;
    rd_idx_d     = rd_idx_q;
    out_valid_d  = out_valid_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.exec) begin
      case (in_mode_i)
        deq_pkg::MODE_PUSH_FRONT: begin
          if (!full) begin
            front_d = front_dec;
            cnt_d   = cnt_q + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::MODE_PUSH_BACK: begin
          if (!full) begin
            cnt_d = cnt_q + deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::MODE_POP_FRONT: begin
          if (!empty) begin
            front_d = front_inc;
            cnt_d   = cnt_q - deq_pkg::CNT_W'(1);
          end
        end
        deq_pkg::MODE_POP_BACK: begin
          if (!empty) begin
            cnt_d = cnt_q - deq_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.rd_clr) begin
      rd_idx_d = '0;
    end

    if (ack_load) begin
      out_valid_d = 1'b1;
      out_value_d = '0;
      out_last_d  = 1'b1;
      if (is_push) begin
        out_status_d = full ? deq_pkg::STATUS_FULL : deq_pkg::STATUS_OK;
      end else begin
        out_status_d = empty ? deq_pkg::STATUS_EMPTY : deq_pkg::STATUS_OK;
      end
    end else if (cmd_i.rd_load) begin
      out_valid_d  = 1'b1;
      out_value_d  = rdata;
      out_status_d = deq_pkg::STATUS_OK;
      out_last_d   = rd_last;
      rd_idx_d     = rd_idx_q + deq_pkg::IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign sts_o.empty    = empty;
  assign sts_o.full     = full;
  assign sts_o.out_free = out_free;
  assign sts_o.rd_last  = rd_last;
  assign sts_o.count    = cnt_q;

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// File: rtl/core/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Response: push, pop and an empty read out answer in the cycle after the word is accepted.
// Throughput: one push/pop word per cycle while the result word is taken each cycle.
// Read out: per entry a store read request then a load (address then data of the store's
// registered read port), no new input word taken until the last entry is handed over.
// Reset: rst_ni clears front pointer, count and controller state; the store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values on a ring store.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [deq_pkg::DATA_W-1:0]   s_axis_tdata,   // [31:0] value
  input  logic [deq_pkg::MODE_W-1:0]   s_axis_tuser,   // [2:0] mode
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [deq_pkg::OUT_W-1:0]    m_axis_tdata,   // [31:0] value_res, [33:32] status
  output logic                         m_axis_tlast    // last
);

  deq_pkg::deq_cmd_t             cmd;
  deq_pkg::deq_sts_t             sts;
  logic [deq_pkg::DATA_W-1:0]    out_value;
  logic [deq_pkg::STATUS_W-1:0]  out_status;

  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  deq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mode_i    (s_axis_tuser),
    .in_value_i   (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_value_o  (out_value),
    .out_status_o (out_status),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{deq_pkg::PAD_W{1'b0}}, out_status, out_value};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.count <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !sts.full &&
     ((s_axis_tuser == deq_pkg::MODE_PUSH_FRONT) ||
      (s_axis_tuser == deq_pkg::MODE_PUSH_BACK)))
    |=> (sts.count == $past(sts.count) + deq_pkg::CNT_W'(1)))
    else $error("push did not grow the count");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> (!s_axis_tready && !cmd.rd_load))
    else $error("output register overwritten while stalled");

  a_read_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_req |-> !sts.empty)
    else $error("store read issued on empty queue");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_ended_queue_unit. A short directed run covers
// the empty and boundary cases and the unused modes. Biased random phases then
// fill, mix and drain the queue. Every result word is checked against a
// deque model kept in the bench, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam int CALM_TAIL     = 40;    // last words go out with no idling
  localparam int SETTLE_CYCLES = 48;    // > a full read out of a full queue
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 90;
  localparam int MAX_REPORTS   = 40;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DATA_W-1:0] value;
    bit                drain_first;  // sender waits until all replies are in
  } op_word_t;

  typedef struct {
    logic [DATA_W-1:0]   value_res;
    logic [STATUS_W-1:0] status;
    logic                last;
  } reply_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata  = '0;
  logic [MODE_W-1:0] s_axis_tuser  = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  op_word_t op_backlog[$];
  reply_t   reply_fifo[$];

  // deque model state
  logic [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]  head_idx = '0;
  logic [CNT_W-1:0]  fill_cnt = '0;

  int error_cnt    = 0;
  int offered_cnt  = 0;
  int taken_cnt    = 0;
  int src_idle     = 0;
  int sink_idle    = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;

  double_ended_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    if (error_cnt < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    error_cnt++;
  endtask

  // Applies one accepted word to the model and queues the replies it causes.
  task automatic apply_deque_op(input logic [MODE_W-1:0] mode,
                                input logic [DATA_W-1:0] value);
    int i;
    case (mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (fill_cnt == DEPTH) begin
          reply_fifo.push_back('{DATA_W'(0), STATUS_FULL, 1'b1});
        end else begin
          if (mode == MODE_PUSH_FRONT) begin
            head_idx = IDX_W'((int'(head_idx) + DEPTH - 1) % DEPTH);
            ring[head_idx] = value;
          end else begin
            ring[IDX_W'((int'(head_idx) + int'(fill_cnt)) % DEPTH)] = value;
          end
          fill_cnt++;
          reply_fifo.push_back('{DATA_W'(0), STATUS_OK, 1'b1});
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (fill_cnt == 0) begin
          reply_fifo.push_back('{DATA_W'(0), STATUS_EMPTY, 1'b1});
        end else begin
          if (mode == MODE_POP_FRONT) begin
            head_idx = IDX_W'((int'(head_idx) + 1) % DEPTH);
          end
          fill_cnt--;
          reply_fifo.push_back('{DATA_W'(0), STATUS_OK, 1'b1});
        end
      end
      MODE_READ_ALL: begin
        if (fill_cnt == 0) begin
          reply_fifo.push_back('{DATA_W'(0), STATUS_EMPTY, 1'b1});
        end else begin
          for (i = 0; i < int'(fill_cnt); i++) begin
            reply_fifo.push_back('{ring[IDX_W'((int'(head_idx) + i) % DEPTH)], STATUS_OK,
                                   (i + 1 == int'(fill_cnt))});
          end
        end
      end
      default: ;  // unused modes: no state change, no reply
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_word(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
                          input bit drain_first);
    op_word_t w;
    w.mode        = mode;
    w.value       = value;
    w.drain_first = drain_first;
    op_backlog.push_back(w);
  endtask

  // Random phase; the percentages bias toward filling or draining the queue.
  task automatic queue_phase(input int words, input int push_pct, input int pop_pct);
    int                n;
    int                roll;
    logic [MODE_W-1:0] m;
    n = 0;
    while (n < words) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end else if (roll < 3 + push_pct) begin
        m = $urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
      end else if (roll < 3 + push_pct + pop_pct) begin
        m = $urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT;
      end else begin
        m = MODE_READ_ALL;
      end
      add_word(m, pick_value(), n == 0);
      if (m <= MODE_READ_ALL) n++;
    end
  endtask

  // input driver: a word, once offered, stays until taken
  always @(negedge clk_i) begin : word_driver
    op_word_t w;
    if (rst_ni && offered_cnt == taken_cnt) begin
      if (src_idle > 0) begin
        src_idle--;
        s_axis_tvalid <= 1'b0;
      end else if (op_backlog.size() == 0 ||
                   (op_backlog[0].drain_first && reply_fifo.size() != 0)) begin
        s_axis_tvalid <= 1'b0;
      end else if (op_backlog.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
        src_idle = $urandom_range(1, 13) - 1;
        s_axis_tvalid <= 1'b0;
      end else begin
        w = op_backlog.pop_front();
        s_axis_tdata  <= w.value;
        s_axis_tuser  <= w.mode;
        s_axis_tvalid <= 1'b1;
        offered_cnt++;
      end
    end
  end

  // result sink: random bursts plus one long hold-off to back up the input
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && taken_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle--;
      m_axis_tready <= 1'b0;
    end else if (op_backlog.size() > CALM_TAIL && $urandom_range(0, 6) == 0) begin
      sink_idle = $urandom_range(1, 13) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // input side first, so a same-edge reply already has its expectation
  always @(posedge clk_i) begin : stream_monitor
    reply_t              want;
    logic [DATA_W-1:0]   got_value;
    logic [STATUS_W-1:0] got_status;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_deque_op(s_axis_tuser, s_axis_tdata);
        taken_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_value  = m_axis_tdata[DATA_W-1:0];
        got_status = m_axis_tdata[DATA_W+STATUS_W-1:DATA_W];
        if (reply_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected word value %0d status %0d last %0b",
                                    $signed(got_value), got_status, m_axis_tlast));
        end else begin
          want = reply_fifo.pop_front();
          if (got_value !== want.value_res)
            report_mismatch($sformatf("value_res %0d, want %0d",
                                      $signed(got_value), $signed(want.value_res)));
          if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", m_axis_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    // empty queue cases and unused modes
    add_word(MODE_READ_ALL, '0, 1'b0);
    add_word(MODE_POP_FRONT, '0, 1'b0);
    add_word(MODE_POP_BACK, '1, 1'b0);
    for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) add_word(MODE_W'(m), $urandom(), 1'b0);
    // extremes at both ends
    add_word(MODE_PUSH_FRONT, 32'h7fff_ffff, 1'b0);
    add_word(MODE_PUSH_BACK, 32'h8000_0000, 1'b0);
    add_word(MODE_PUSH_FRONT, '0, 1'b0);
    add_word(MODE_PUSH_BACK, '1, 1'b0);
    add_word(MODE_READ_ALL, $urandom(), 1'b0);
    add_word(MODE_POP_FRONT, $urandom(), 1'b0);
    add_word(MODE_POP_BACK, $urandom(), 1'b0);
    add_word(MODE_READ_ALL, '0, 1'b0);
    // pop the only entry from either end
    add_word(MODE_POP_BACK, '0, 1'b0);
    add_word(MODE_POP_FRONT, '0, 1'b0);
    add_word(MODE_READ_ALL, '0, 1'b0);
    add_word(MODE_PUSH_BACK, $urandom(), 1'b0);
    add_word(MODE_POP_BACK, '0, 1'b0);
    // fill / mix / drain, twice
    queue_phase(60, 75, 10);
    queue_phase(70, 45, 40);
    queue_phase(50, 15, 75);
    queue_phase(60, 75, 10);
    queue_phase(60, 45, 40);
    queue_phase(50, 15, 75);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || offered_cnt != taken_cnt || reply_fifo.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: double_ended_queue_unit.f
rtl/core/deq_pkg.sv
rtl/core/deq_ram.sv
rtl/core/deq_ctrl.sv
rtl/core/deq_dp.sv
rtl/core/double_ended_queue_unit.sv
tb/tb.sv
